[hw/rtl/ftt_pkg.sv]
`default_nettype none

package ftt_pkg;

    localparam int KEY_W  = 32;
    localparam int TIME_W = 64;

    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_LOOKUP = 2'd1;
    localparam logic [1:0] OP_CLEAR  = 2'd2;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_FULL     = 2'd1;
    localparam logic [1:0] ST_NOTFOUND = 2'd2;

endpackage

`default_nettype wire

[hw/rtl/frame_timestamp_table_core.sv]
// Channel   Dir  Handshake          Payload
// s_        in   s_tvalid/s_tready  s_tuser: opcode; s_tdata: frame_key, now_time, erase_on_hit
// m_        out  m_tvalid/m_tready  m_tuser: status; m_tdata: stored_time
//
// One transaction at a time; s_tready is high only while the sequencer is idle.
// Insert scans the busy flags for the first free entry and lookup scans the key RAM,
// one entry per cycle; clear and unused opcodes go straight to the result state.
// aresetn (synchronous) frees all entries at once; key and time RAMs are not cleared.
// A result waits in the output register while m_tready is low; the sequencer holds
// its finished result until that register is free.
`default_nettype none

module frame_timestamp_table_core #(
    parameter int NUM_ENTRIES = 20
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [103:0] s_tdata,   // [31:0] frame_key, [95:32] now_time,
                                         // [96] erase_on_hit, [103:97] zero
    input  wire logic [1:0]   s_tuser,   // [1:0] opcode
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic [63:0]       m_tdata,   // [63:0] stored_time
    output logic [1:0]        m_tuser    // [1:0] status
);

    localparam int IW = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;
    localparam int CW = $clog2(NUM_ENTRIES + 1);
    localparam logic [CW-1:0] END_IDX = CW'(NUM_ENTRIES);

    typedef enum logic [1:0] {
        S_IDLE,
        S_INSERT,
        S_LOOKUP,
        S_DONE
    } state_t;

    state_t                          state_reg;
    logic [CW-1:0]                   idx_reg;
    logic [IW-1:0]                   rd_idx_reg;
    logic                            rd_valid_reg;
    logic [NUM_ENTRIES-1:0]          busy_reg;
    logic [ftt_pkg::KEY_W-1:0]       key_reg;
    logic [ftt_pkg::TIME_W-1:0]      time_reg;
    logic                            erase_reg;
    logic [1:0]                      res_status_reg;
    logic [ftt_pkg::TIME_W-1:0]      res_time_reg;
    logic                            m_tvalid_reg;
    logic [1:0]                      m_status_reg;
    logic [ftt_pkg::TIME_W-1:0]      m_time_reg;

    logic                            s_accept;
    logic                            in_range;
    logic                            cur_free;
    logic                            rd_hit;
    logic                            ram_we;
    logic [IW-1:0]                   ram_raddr;
    logic [ftt_pkg::KEY_W-1:0]       key_rdata;
    logic [ftt_pkg::TIME_W-1:0]      time_rdata;
    logic                            out_free;

    assign s_tready  = (state_reg == S_IDLE);
    assign s_accept  = s_tvalid && s_tready;
    assign in_range  = (idx_reg < END_IDX);
    assign cur_free  = in_range && !busy_reg[idx_reg[IW-1:0]];
    assign rd_hit    = rd_valid_reg && busy_reg[rd_idx_reg] && (key_rdata == key_reg);
    assign ram_we    = (state_reg == S_INSERT) && cur_free;
    assign ram_raddr = in_range ? idx_reg[IW-1:0] : '0;
    assign out_free  = !m_tvalid_reg || m_tready;

    ftt_ram #(
        .WIDTH(ftt_pkg::KEY_W),
        .DEPTH(NUM_ENTRIES)
    ) u_key_ram (
        .clk    (aclk),
        .wr_en  (ram_we),
        .wr_addr(idx_reg[IW-1:0]),
        .wr_data(key_reg),
        .rd_addr(ram_raddr),
        .rd_data(key_rdata)
    );

    ftt_ram #(
        .WIDTH(ftt_pkg::TIME_W),
        .DEPTH(NUM_ENTRIES)
    ) u_time_ram (
        .clk    (aclk),
        .wr_en  (ram_we),
        .wr_addr(idx_reg[IW-1:0]),
        .wr_data(time_reg),
        .rd_addr(ram_raddr),
        .rd_data(time_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            busy_reg     <= '0;
            rd_valid_reg <= 1'b0;
            m_tvalid_reg <= 1'b0;
            idx_reg      <= '0;
        end else begin
            if (m_tvalid_reg && m_tready && (state_reg != S_DONE)) begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE: begin
                    if (s_accept) begin
                        key_reg        <= s_tdata[31:0];
                        time_reg       <= s_tdata[95:32];
                        erase_reg      <= s_tdata[96];
                        idx_reg        <= '0;
                        rd_valid_reg   <= 1'b0;
                        res_status_reg <= ftt_pkg::ST_OK;
                        res_time_reg   <= '0;
                        unique case (s_tuser)
                            ftt_pkg::OP_INSERT: state_reg <= S_INSERT;
                            ftt_pkg::OP_LOOKUP: state_reg <= S_LOOKUP;
                            ftt_pkg::OP_CLEAR: begin
                                busy_reg  <= '0;
                                state_reg <= S_DONE;
                            end
                            default: state_reg <= S_DONE;
                        endcase
                    end
                end
                S_INSERT: begin
                    if (!in_range) begin
                        res_status_reg <= ftt_pkg::ST_FULL;
                        state_reg      <= S_DONE;
                    end else if (cur_free) begin
                        busy_reg[idx_reg[IW-1:0]] <= 1'b1;
                        state_reg                 <= S_DONE;
                    end else begin
                        idx_reg <= idx_reg + 1'b1;
                    end
                end
                S_LOOKUP: begin
                    if (rd_hit) begin
                        res_time_reg <= time_rdata;
                        if (erase_reg) begin
                            busy_reg[rd_idx_reg] <= 1'b0;
                        end
                        state_reg <= S_DONE;
                    end else if (!rd_valid_reg && !in_range) begin
                        res_status_reg <= ftt_pkg::ST_NOTFOUND;
                        state_reg      <= S_DONE;
                    end else begin
                        rd_valid_reg <= in_range;
                        rd_idx_reg   <= ram_raddr;
                        if (in_range) begin
                            idx_reg <= idx_reg + 1'b1;
                        end
                    end
                end
                S_DONE: begin
                    if (out_free) begin
                        m_tvalid_reg <= 1'b1;
                        m_status_reg <= res_status_reg;
                        m_time_reg   <= res_time_reg;
                        state_reg    <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = m_status_reg;
    assign m_tdata  = m_time_reg;

    a_clear_frees_all: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && s_tuser == ftt_pkg::OP_CLEAR) |=> (busy_reg == '0))
        else $error("clear left a busy entry");

    a_insert_adds_one: assert property (@(posedge aclk) disable iff (!aresetn)
        ram_we |=> ($countones(busy_reg) == $past($countones(busy_reg)) + 1))
        else $error("insert did not claim exactly one free entry");

    a_full_only_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_DONE && res_status_reg == ftt_pkg::ST_FULL) |-> (&busy_reg))
        else $error("full status with a free entry");

    a_erase_frees_one: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_LOOKUP && rd_hit && erase_reg)
            |=> ($countones(busy_reg) + 1 == $past($countones(busy_reg))))
        else $error("erase on hit did not free exactly one entry");

    a_busy_idle_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_DONE) |=> $stable(busy_reg))
        else $error("entry state changed while a result was pending");

endmodule

`default_nettype wire

[hw/rtl/ftt_ram.sv]
`default_nettype none

module ftt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 20
) (
    input  wire logic                                  clk,
    input  wire logic                                  wr_en,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]                      wr_data,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic      [WIDTH-1:0]                      rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire
